### src/hkl_pkg.sv
// Shared types, codes and constants of the hashed key-value table.
`default_nettype none
package hkl_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SLOT_W   = 8;
  localparam int ECNT_W   = 9;
  localparam int HASH_W   = 64;
  localparam int VAL_W    = 64;
  localparam int HIT_W    = 32;

  localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
  localparam int                HASH_SHL  = 5;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_FIND  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_FOUND   = 3'd1;
  localparam logic [2:0] ST_MISSING = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [1:0]        op;
    logic [HASH_W-1:0] hash;
    logic [VAL_W-1:0]  value;
  } cmd_t;

endpackage
`default_nettype wire

### src/hkl_front.sv
// Front end: hashes key bytes and turns terminators and clears into commands.
`default_nettype none
module hkl_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [1:0]   in_opcode,
  input  wire logic [7:0]   in_key_byte,
  input  wire logic [63:0]  in_value,
  output logic              push_valid,
  input  wire logic         push_ready,
  output hkl_pkg::cmd_t     push_cmd
);
  import hkl_pkg::*;

  logic [HASH_W-1:0] acc_r, acc_nxt;
  logic              kip_r, kip_nxt;
  logic [HASH_W-1:0] base, mix;
  logic              accept, term;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign term     = (in_opcode == OP_ADD || in_opcode == OP_FIND) && (in_key_byte == 8'd0);

  assign base = kip_r ? acc_r : HASH_SEED;
  assign mix  = (base << HASH_SHL) + base + {{(HASH_W-8){1'b0}}, in_key_byte};

  always_comb begin
    acc_nxt = acc_r;
    kip_nxt = kip_r;
    if (accept) begin
      if (in_opcode == OP_CLEAR || term) begin
        acc_nxt = '0;
        kip_nxt = 1'b0;
      end else if (in_opcode != OP_NONE) begin
        acc_nxt = mix;
        kip_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      kip_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      kip_r <= kip_nxt;
    end
  end

  assign push_valid     = accept && (in_opcode == OP_CLEAR || term);
  assign push_cmd.op    = in_opcode;
  assign push_cmd.hash  = (in_opcode == OP_CLEAR || !kip_r) ? '0 : mix;
  assign push_cmd.value = in_value;

endmodule
`default_nettype wire

### src/hkl_queue.sv
// Two-entry command queue between front and back.
`default_nettype none
module hkl_queue (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     wr_valid,
  output logic          wr_ready,
  input  hkl_pkg::cmd_t wr_cmd,
  output logic          rd_valid,
  input  wire logic     rd_ready,
  output hkl_pkg::cmd_t rd_cmd
);
  import hkl_pkg::*;

  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_cmd   = q_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop)
      cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push)
      cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push)
      q_r[wp_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### src/hkl_back.sv
// Back end: entry memories, add, clear and the sequential find scan.
`default_nettype none
module hkl_back (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cmd_valid,
  output logic              cmd_ready,
  input  hkl_pkg::cmd_t     cmd,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [2:0]        out_status,
  output logic [7:0]        out_slot,
  output logic [63:0]       out_found_value,
  output logic [31:0]       out_hit_count,
  output logic [63:0]       out_key_hash,
  output logic [8:0]        out_entry_count
);
  import hkl_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic [HASH_W-1:0] hash_mem [CAPACITY];
  logic [VAL_W-1:0]  val_mem  [CAPACITY];
  logic [HIT_W-1:0]  hit_mem  [CAPACITY];

  logic              state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [HASH_W-1:0] key_r;
  logic [HASH_W-1:0] rd_hash_r;
  logic [VAL_W-1:0]  rd_val_r;
  logic [HIT_W-1:0]  rd_hit_r;
  logic [HIT_W-1:0]  hit_sat;

  logic              ov_r, ov_nxt;
  logic [2:0]        os_r, os_nxt;
  logic [SLOT_W-1:0] oslot_r, oslot_nxt;
  logic [VAL_W-1:0]  oval_r, oval_nxt;
  logic [HIT_W-1:0]  ohit_r, ohit_nxt;
  logic [HASH_W-1:0] ohash_r, ohash_nxt;

  logic              pop, hit, miss, issue, full;
  logic              ent_we, hit_we;
  logic [IDX_W-1:0]  hit_waddr;
  logic [HIT_W-1:0]  hit_wdata;

  assign cmd_ready = (state_r == S_IDLE) && (!ov_r || out_ready);
  assign pop       = cmd_valid && cmd_ready;
  assign full      = (count_r >= CNT_W'(CAPACITY));
  assign hit       = (state_r == S_SCAN) && rd_vld_r && (rd_hash_r == key_r);
  assign miss      = (state_r == S_SCAN) && !rd_vld_r && (scan_r >= count_r);
  assign issue     = (state_r == S_SCAN) && !hit && (scan_r < count_r);
  assign hit_sat   = (rd_hit_r == '1) ? rd_hit_r : rd_hit_r + HIT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    scan_nxt   = scan_r;
    rd_vld_nxt = 1'b0;
    ov_nxt     = ov_r && !out_ready;
    os_nxt     = os_r;
    oslot_nxt  = oslot_r;
    oval_nxt   = oval_r;
    ohit_nxt   = ohit_r;
    ohash_nxt  = ohash_r;
    ent_we     = 1'b0;
    hit_we     = 1'b0;
    hit_waddr  = count_r[IDX_W-1:0];
    hit_wdata  = '0;
    case (state_r)
      S_IDLE: begin
        if (pop) begin
          oslot_nxt = '0;
          oval_nxt  = '0;
          ohit_nxt  = '0;
          ohash_nxt = cmd.hash;
          case (cmd.op)
            OP_CLEAR: begin
              count_nxt = '0;
              ov_nxt    = 1'b1;
              os_nxt    = ST_CLEARED;
              ohash_nxt = '0;
            end
            OP_ADD: begin
              ov_nxt = 1'b1;
              if (full) begin
                os_nxt = ST_FULL;
              end else begin
                ent_we    = 1'b1;
                hit_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                os_nxt    = ST_ADDED;
                oslot_nxt = SLOT_W'(count_r[IDX_W-1:0]);
              end
            end
            default: begin
              state_nxt = S_SCAN;
              scan_nxt  = '0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (issue) begin
          scan_nxt   = scan_r + CNT_W'(1);
          rd_vld_nxt = 1'b1;
        end
        if (hit) begin
          state_nxt = S_IDLE;
          hit_we    = 1'b1;
          hit_waddr = rd_idx_r;
          hit_wdata = hit_sat;
          ov_nxt    = 1'b1;
          os_nxt    = ST_FOUND;
          oslot_nxt = SLOT_W'(rd_idx_r);
          oval_nxt  = rd_val_r;
          ohit_nxt  = hit_sat;
        end else if (miss) begin
          state_nxt = S_IDLE;
          ov_nxt    = 1'b1;
          os_nxt    = ST_MISSING;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      hash_mem[count_r[IDX_W-1:0]] <= cmd.hash;
      val_mem[count_r[IDX_W-1:0]]  <= cmd.value;
    end
    if (hit_we)
      hit_mem[hit_waddr] <= hit_wdata;
    rd_hash_r <= hash_mem[scan_r[IDX_W-1:0]];
    rd_val_r  <= val_mem[scan_r[IDX_W-1:0]];
    rd_hit_r  <= hit_mem[scan_r[IDX_W-1:0]];
    rd_idx_r  <= scan_r[IDX_W-1:0];
    if (pop)
      key_r <= cmd.hash;
    os_r    <= os_nxt;
    oslot_r <= oslot_nxt;
    oval_r  <= oval_nxt;
    ohit_r  <= ohit_nxt;
    ohash_r <= ohash_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      scan_r   <= scan_nxt;
      rd_vld_r <= rd_vld_nxt;
      ov_r     <= ov_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = os_r;
  assign out_slot        = oslot_r;
  assign out_found_value = oval_r;
  assign out_hit_count   = ohit_r;
  assign out_key_hash    = ohash_r;
  assign out_entry_count = ECNT_W'(count_r);

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY)) else $error("entry count beyond capacity");
  a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !ov_r) else $error("result pending during scan");
  a_single_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (cmd.op == OP_ADD || cmd.op == OP_CLEAR)) |=> ov_r)
    else $error("add or clear gave no result");
  a_hit_once: assert property (@(posedge clk) disable iff (!rst_n)
    hit |=> (state_r == S_IDLE)) else $error("scan kept running after a hit");
`endif

endmodule
`default_nettype wire

### src/hash_keyed_lookup_table.sv
// Top level of the djb2-hashed key-value table.
// Key bytes are taken one per cycle and hashed in the front end; a zero
// byte or a clear turns into a command in a two-entry queue. Add, full
// and clear commands complete in the back end without a scan. Find scans
// the occupied slots in insertion order, one entry per cycle through the
// registered read port of the hash memory, and keeps the back end busy
// until a hit or the end of the entries; the queue fills behind it and
// input stalls only when both entries are taken. The table holds 256
// entries; it needs no clearing pass after reset since only slots below
// the entry count are read.
`default_nettype none
module hash_keyed_lookup_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_key_byte,
  input  wire logic [63:0] in_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_status,
  output logic [7:0]       out_slot,
  output logic [63:0]      out_found_value,
  output logic [31:0]      out_hit_count,
  output logic [63:0]      out_key_hash,
  output logic [8:0]       out_entry_count
);
  import hkl_pkg::*;

  cmd_t push_cmd, q_cmd;
  logic push_valid, push_ready, q_valid, q_ready;

  hkl_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_key_byte (in_key_byte),
    .in_value    (in_value),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  hkl_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_cmd   (push_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  hkl_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_valid),
    .cmd_ready       (q_ready),
    .cmd             (q_cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_found_value (out_found_value),
    .out_hit_count   (out_hit_count),
    .out_key_hash    (out_key_hash),
    .out_entry_count (out_entry_count)
  );

endmodule
`default_nettype wire

### test/hash_keyed_lookup_table_check.sv
// Result predictor and comparator for the hashed key-value table.
module hash_keyed_lookup_table_check (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_key_byte,
  input  logic [63:0]       in_value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [2:0]        out_status,
  input  logic [7:0]        out_slot,
  input  logic [63:0]       out_found_value,
  input  logic [31:0]       out_hit_count,
  input  logic [63:0]       out_key_hash,
  input  logic [8:0]        out_entry_count,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import hkl_pkg::*;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  found_value;
    logic [HIT_W-1:0]  hit_count;
    logic [HASH_W-1:0] key_hash;
    logic [ECNT_W-1:0] entry_count;
  } table_result_t;

  table_result_t     pending_results[$];
  table_result_t     oldest;
  logic [HASH_W-1:0] hash_acc;
  bit                key_open;
  logic [HASH_W-1:0] entry_hash  [CAPACITY];
  logic [VAL_W-1:0]  entry_value [CAPACITY];
  logic [HIT_W-1:0]  entry_hits  [CAPACITY];
  int unsigned       entries_held;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic table_step(input logic [1:0] op, input logic [7:0] kb,
                            input logic [63:0] v);
    logic [HASH_W-1:0] h;
    table_result_t     r;
    bit                hit;
    r   = '0;
    hit = 1'b0;
    if (op == OP_NONE) return;
    if (op == OP_CLEAR) begin
      entries_held = 0;
      hash_acc     = '0;
      key_open     = 1'b0;
      r.status     = ST_CLEARED;
      pending_results.push_back(r);
      return;
    end
    if (kb != 8'h00) begin
      if (!key_open) hash_acc = HASH_SEED;
      hash_acc = (hash_acc << HASH_SHL) + hash_acc + HASH_W'(kb);
      key_open = 1'b1;
      return;
    end
    h = key_open ? (hash_acc << HASH_SHL) + hash_acc : '0;
    hash_acc   = '0;
    key_open   = 1'b0;
    r.key_hash = h;
    if (op == OP_ADD) begin
      if (entries_held >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        entry_hash[entries_held]  = h;
        entry_value[entries_held] = v;
        entry_hits[entries_held]  = '0;
        r.status     = ST_ADDED;
        r.slot       = SLOT_W'(entries_held);
        entries_held = entries_held + 1;
      end
    end else begin
      r.status = ST_MISSING;
      for (int i = 0; i < entries_held && !hit; i++) begin
        if (entry_hash[i] == h) begin
          hit = 1'b1;
          if (entry_hits[i] != '1) entry_hits[i] = entry_hits[i] + 1'b1;
          r.status      = ST_FOUND;
          r.slot        = SLOT_W'(i);
          r.found_value = entry_value[i];
          r.hit_count   = entry_hits[i];
        end
      end
    end
    r.entry_count = ECNT_W'(entries_held);
    pending_results.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      hash_acc     = '0;
      key_open     = 1'b0;
      entries_held = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: unexpected item, expected none, got status %0d hash %0h",
                   $time, out_status, out_key_hash);
          mismatches++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("status", 64'(oldest.status), 64'(out_status));
          check_field("slot", 64'(oldest.slot), 64'(out_slot));
          check_field("found_value", oldest.found_value, out_found_value);
          check_field("hit_count", 64'(oldest.hit_count), 64'(out_hit_count));
          check_field("key_hash", oldest.key_hash, out_key_hash);
          check_field("entry_count", 64'(oldest.entry_count), 64'(out_entry_count));
        end
      end
      if (in_valid && in_ready) table_step(in_opcode, in_key_byte, in_value);
    end
    outstanding = pending_results.size();
  end

endmodule

### test/hash_keyed_lookup_table_test.sv
// Stimulus, clocking and verdict for the hashed key-value table.
module hash_keyed_lookup_table_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hkl_pkg::*;

  localparam int CYCLE_LIMIT  = 2000000;
  localparam int HOLD_CYCLES  = 500;
  localparam int DRAIN_CYCLES = 300;
  localparam int POOL_DEPTH   = 32;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode   = OP_NONE;
  logic [7:0]  in_key_byte = 8'h00;
  logic [63:0] in_value    = 64'h0;
  logic        out_valid;
  logic        out_ready   = 1'b0;
  logic [2:0]  out_status;
  logic [7:0]  out_slot;
  logic [63:0] out_found_value;
  logic [31:0] out_hit_count;
  logic [63:0] out_key_hash;
  logic [8:0]  out_entry_count;

  int unsigned mismatches;
  int unsigned outstanding;
  int unsigned items_sent = 0;
  int unsigned cycles     = 0;
  int          burst_left = 0;
  int          hold_req   = 0;

  logic [63:0] pool_key [POOL_DEPTH];
  int          pool_len [POOL_DEPTH];
  int          pool_size = 0;

  hash_keyed_lookup_table DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_key_byte(in_key_byte), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_slot(out_slot),
    .out_found_value(out_found_value), .out_hit_count(out_hit_count),
    .out_key_hash(out_key_hash), .out_entry_count(out_entry_count)
  );

  hash_keyed_lookup_table_check result_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_opcode(in_opcode), .in_key_byte(in_key_byte), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_slot(out_slot),
    .out_found_value(out_found_value), .out_hit_count(out_hit_count),
    .out_key_hash(out_key_hash), .out_entry_count(out_entry_count),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk) cycles++;
    $display("** hash_keyed_lookup_table: FAILED **");
    $finish;
  end

  // receiver: own stall pattern, plus long hold-offs on request
  initial begin
    int mode;
    int left;
    int served;
    mode   = 0;
    left   = 0;
    served = 0;
    while (!rst_n) @(negedge clk);
    forever begin
      @(negedge clk);
      if (served < hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        served++;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(16, 96);
        end
        left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 7) != 0);
          default: out_ready <= (left % 3 == 0);
        endcase
      end
    end
  end

  function automatic logic [63:0] random_value();
    case ($urandom_range(0, 9))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] kb,
                           input logic [63:0] v);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(0, 6));
    end
    burst_left--;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_opcode   <= op;
    in_key_byte <= kb;
    in_value    <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_NONE) items_sent++;
  endtask

  // key bytes, then the zero terminator carrying the operation
  task automatic send_key(input logic [63:0] key, input int len,
                          input logic [1:0] end_op, input logic [63:0] v,
                          input bit mix);
    for (int i = 0; i < len; i++) begin
      if (mix && $urandom_range(0, 15) == 0)
        send_item(OP_NONE, 8'($urandom_range(0, 255)), random_value());
      if (mix)
        send_item($urandom_range(0, 1) ? OP_FIND : OP_ADD, key[8*i +: 8], random_value());
      else
        send_item(end_op, key[8*i +: 8], random_value());
    end
    send_item(end_op, 8'h00, v);
  endtask

  task automatic make_key(output logic [63:0] key, output int len, input int max_len);
    len = $urandom_range(0, max_len);
    key = '0;
    for (int i = 0; i < len; i++) key[8*i +: 8] = 8'($urandom_range(1, 255));
  endtask

  task automatic remember_key(input logic [63:0] key, input int len);
    int idx;
    idx = (pool_size < POOL_DEPTH) ? pool_size : $urandom_range(0, POOL_DEPTH - 1);
    if (pool_size < POOL_DEPTH) pool_size++;
    pool_key[idx] = key;
    pool_len[idx] = len;
  endtask

  task automatic pick_key(output logic [63:0] key, output int len);
    int idx;
    if (pool_size == 0) begin
      make_key(key, len, 6);
    end else begin
      idx = $urandom_range(0, pool_size - 1);
      key = pool_key[idx];
      len = pool_len[idx];
    end
  endtask

  task automatic random_mix(input int unsigned item_goal);
    logic [63:0] key;
    int          len;
    int          r;
    while (items_sent < item_goal) begin
      if (items_sent >= 300 && hold_req == 0) hold_req = 1;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        make_key(key, len, 4);
        for (int i = 0; i < len; i++) send_item(OP_ADD, key[8*i +: 8], random_value());
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)), random_value());
      end else if (r < 5) begin
        send_item(OP_CLEAR, 8'($urandom_range(0, 255)), random_value());
      end else if (r < 50) begin
        if ($urandom_range(0, 4) == 0) pick_key(key, len);
        else make_key(key, len, 6);
        send_key(key, len, OP_ADD, random_value(), $urandom_range(0, 3) == 0);
        remember_key(key, len);
      end else begin
        if ($urandom_range(0, 9) < 7) pick_key(key, len);
        else make_key(key, len, 6);
        send_key(key, len, OP_FIND, random_value(), $urandom_range(0, 3) == 0);
      end
    end
  endtask

  // fill past capacity with short keys, finds in between
  task automatic fill_table();
    logic [63:0] key;
    int          len;
    send_item(OP_CLEAR, 8'h00, 64'h0);
    for (int n = 0; n < 270; n++) begin
      if (n == 150) hold_req = 2;
      make_key(key, len, 1);
      send_key(key, len, OP_ADD, random_value(), 1'b0);
      remember_key(key, len);
      if (n % 8 == 7) begin
        pick_key(key, len);
        send_key(key, len, OP_FIND, random_value(), 1'b0);
      end
    end
    repeat (4) begin
      make_key(key, len, 6);
      send_key(key, len, OP_FIND, random_value(), 1'b1);
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    send_item(OP_ADD, 8'h00, '1);
    send_item(OP_FIND, 8'h00, 64'h0);
    send_item(OP_FIND, 8'hFF, 64'h0);
    send_item(OP_ADD, 8'h01, '1);
    send_item(OP_ADD, 8'h00, 64'h0);
    send_key(64'h01FF, 2, OP_FIND, '1, 1'b0);
    send_item(OP_ADD, 8'h41, 64'h0);
    send_item(OP_NONE, 8'h00, '1);
    send_item(OP_FIND, 8'h42, 64'h0);
    send_item(OP_FIND, 8'h00, 64'h0);
    send_key(64'h4241, 2, OP_ADD, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_key(64'h4241, 2, OP_ADD, 64'hFEDC_BA98_7654_3210, 1'b0);
    send_key(64'h4241, 2, OP_FIND, 64'h0, 1'b0);
    send_key(64'h80, 1, OP_FIND, '1, 1'b0);
    send_item(OP_ADD, 8'h33, 64'h0);
    send_item(OP_CLEAR, 8'h7F, '1);
    send_item(OP_FIND, 8'h00, 64'h0);
    send_item(OP_CLEAR, 8'h00, 64'h0);
    send_item(OP_NONE, 8'hFF, '1);

    random_mix(650);
    fill_table();
    random_mix(1650);

    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("** hash_keyed_lookup_table: PASSED **");
    else
      $display("** hash_keyed_lookup_table: FAILED **");
    $finish;
  end

endmodule
